@@ hw/rtl/hlsrgb_pkg.sv @@
// hlsrgb_pkg: shared types and defaults for the hls to rgb converter
// no dependencies; used by hlsrgb_select and hls_to_rgb_convert_core
`default_nettype none

package hlsrgb_pkg;

  localparam int FRAC_BITS_DEF     = 12;
  localparam int HUE_FRAC_BITS_DEF = 4;

  // 60 degree hue sectors, named by the channel order max/ramp/min
  typedef enum logic [2:0] {
    SEC_R_MAX_G_UP   = 3'd0,
    SEC_G_MAX_R_DOWN = 3'd1,
    SEC_G_MAX_B_UP   = 3'd2,
    SEC_B_MAX_G_DOWN = 3'd3,
    SEC_B_MAX_R_UP   = 3'd4,
    SEC_R_MAX_B_DOWN = 3'd5
  } sector_t;

endpackage

`default_nettype wire

@@ hw/rtl/hls_to_rgb_convert_core.sv @@
// hls_to_rgb_convert_core: six stage pipelined hue/lightness/saturation to rgb converter
// depends on hlsrgb_pkg and hlsrgb_select
//
// usage:
//   input channel: in_valid / in_stall with hue (signed, 1/16 degree),
//   saturation and lightness (signed Q12, clamped to 0..1.0).
//   output channel: out_valid / out_stall with red, green, blue (Q1.12, 0..4096).
//   a beat is taken on a rising edge with valid high and stall low.
//   throughput: one beat per cycle while the output is not stalled; each of the six stages holds one beat and
//   the two multipliers (lightness by saturation, span by ramp offset) and the
//   reciprocal multiply for the divide by the 60 degree sector each sit in a
//   stage of their own.
//   a stage loads whenever it is empty or the stage after it moves, so bubbles
//   close up; in_stall rises only when all six stages hold beats and the output
//   beat is stalled.
//   stall on the output holds the output beat steady and backs up the pipe.
//   reset (rst, synchronous) empties all stages; no other state.
`default_nettype none

module hls_to_rgb_convert_core #(
  parameter int FRAC_BITS     = hlsrgb_pkg::FRAC_BITS_DEF,
  parameter int HUE_FRAC_BITS = hlsrgb_pkg::HUE_FRAC_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [HUE_FRAC_BITS+10:0] hue,
  input  wire  signed [FRAC_BITS+1:0]     saturation,
  input  wire  signed [FRAC_BITS+1:0]     lightness,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic        [FRAC_BITS:0]       red,
  output logic        [FRAC_BITS:0]       green,
  output logic        [FRAC_BITS:0]       blue
);
  import hlsrgb_pkg::*;

  localparam int IW = FRAC_BITS + 2;
  localparam int OW = FRAC_BITS + 1;
  localparam int HW = HUE_FRAC_BITS + 11;
  localparam int TW = HUE_FRAC_BITS + 6;
  localparam int PW = OW + TW;
  localparam int XW = PW - (HUE_FRAC_BITS + 2);
  localparam int RW = FRAC_BITS + 5;
  localparam int QW = XW + RW;
  localparam int RSH = FRAC_BITS + 8;

  localparam logic signed [IW-1:0] ONE_S  = IW'(64'(1) << FRAC_BITS);
  localparam logic        [OW-1:0] ONE_U  = OW'(64'(1) << FRAC_BITS);
  localparam logic        [OW-1:0] HALF_U = ONE_U >> 1;
  localparam logic signed [HW-1:0] FULL   = HW'(360 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D1 = (HW+1)'(60 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D2 = (HW+1)'(120 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D3 = (HW+1)'(180 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D4 = (HW+1)'(240 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D5 = (HW+1)'(300 * (1 << HUE_FRAC_BITS));
  localparam logic signed [HW:0]   D6 = (HW+1)'(360 * (1 << HUE_FRAC_BITS));
  localparam logic        [TW-1:0] SECT_U = TW'(60 * (1 << HUE_FRAC_BITS));
  // floor(2^RSH / 15), estimate is low by at most one
  localparam logic        [RW-1:0] RECIP = RW'((64'(1) << RSH) / 15);
  localparam logic        [XW-1:0] FIFTEEN = XW'(15);

  // stage valids and load enables
  logic s1_v, s2_v, s3_v, s4_v, s5_v;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign ld6 = !out_valid || !out_stall;
  assign ld5 = !s5_v || ld6;
  assign ld4 = !s4_v || ld5;
  assign ld3 = !s3_v || ld4;
  assign ld2 = !s2_v || ld3;
  assign ld1 = !s1_v || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
      s4_v <= 1'b0; s5_v <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (ld1) s1_v <= in_valid;
      if (ld2) s2_v <= s1_v;
      if (ld3) s3_v <= s2_v;
      if (ld4) s4_v <= s3_v;
      if (ld5) s5_v <= s4_v;
      if (ld6) out_valid <= s5_v;
    end
  end

  // stage 1: clamp and hue wrap
  logic        [OW-1:0] s_clamp, l_clamp;
  logic signed [HW-1:0] h_wrap;
  logic        [OW-1:0] s1_s, s1_l;
  logic signed [HW-1:0] s1_h;

  always_comb begin
    if (saturation[IW-1]) s_clamp = '0;
    else if (saturation > ONE_S) s_clamp = ONE_U;
    else s_clamp = saturation[OW-1:0];
    if (lightness[IW-1]) l_clamp = '0;
    else if (lightness > ONE_S) l_clamp = ONE_U;
    else l_clamp = lightness[OW-1:0];
    if (hue < 0) h_wrap = hue + FULL;
    else if (hue > FULL) h_wrap = hue - FULL;
    else h_wrap = hue;
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_s <= s_clamp;
      s1_l <= l_clamp;
      s1_h <= h_wrap;
    end
  end

  // stage 2: chroma product, sector decode and ramp offset
  logic        [OW-1:0]   mul_b;
  logic        [2*OW-1:0] chroma_prod;
  logic signed [HW:0]     h_x, t_raw;
  logic        [TW-1:0]   t_sat;
  sector_t                sec_next;
  logic        [OW-1:0]   s2_l;
  logic        [2*OW-1:0] s2_prod;
  sector_t                s2_sec;
  logic        [TW-1:0]   s2_t;

  always_comb begin
    mul_b = (s1_l <= HALF_U) ? s1_l : ONE_U - s1_l;
    chroma_prod = (2*OW)'(s1_s) * (2*OW)'(mul_b);
    h_x = {s1_h[HW-1], s1_h};
    if (h_x < D1) begin
      sec_next = SEC_R_MAX_G_UP;   t_raw = h_x;
    end else if (h_x < D2) begin
      sec_next = SEC_G_MAX_R_DOWN; t_raw = D2 - h_x;
    end else if (h_x < D3) begin
      sec_next = SEC_G_MAX_B_UP;   t_raw = h_x - D2;
    end else if (h_x < D4) begin
      sec_next = SEC_B_MAX_G_DOWN; t_raw = D4 - h_x;
    end else if (h_x < D5) begin
      sec_next = SEC_B_MAX_R_UP;   t_raw = h_x - D4;
    end else begin
      sec_next = SEC_R_MAX_B_DOWN; t_raw = D6 - h_x;
    end
    if (t_raw[HW]) t_sat = '0;
    else if (t_raw > D1) t_sat = SECT_U;
    else t_sat = t_raw[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_l    <= s1_l;
      s2_prod <= chroma_prod;
      s2_sec  <= sec_next;
      s2_t    <= t_sat;
    end
  end

  // stage 3: max, min and span
  logic    [OW-1:0] half_span;
  logic    [OW-1:0] s3_mx, s3_mn, s3_diff;
  sector_t          s3_sec;
  logic    [TW-1:0] s3_t;

  assign half_span = s2_prod[FRAC_BITS +: OW];

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_mx   <= s2_l + half_span;
      s3_mn   <= s2_l - half_span;
      s3_diff <= {half_span[OW-2:0], 1'b0};
      s3_sec  <= s2_sec;
      s3_t    <= s2_t;
    end
  end

  // stage 4: span times ramp offset
  logic    [PW-1:0] s4_p;
  logic    [OW-1:0] s4_mx, s4_mn;
  sector_t          s4_sec;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_p   <= PW'(s3_diff) * PW'(s3_t);
      s4_mx  <= s3_mx;
      s4_mn  <= s3_mn;
      s4_sec <= s3_sec;
    end
  end

  // stage 5: divide by the sector width, shift then reciprocal of 15
  logic    [XW-1:0] x_shift;
  logic    [QW-1:0] q_full;
  logic    [XW-1:0] s5_x;
  logic    [OW-1:0] s5_q;
  logic    [OW-1:0] s5_mx, s5_mn;
  sector_t          s5_sec;

  assign x_shift = s4_p[PW-1:HUE_FRAC_BITS+2];
  assign q_full  = QW'(x_shift) * QW'(RECIP);

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_x   <= x_shift;
      s5_q   <= q_full[RSH +: OW];
      s5_mx  <= s4_mx;
      s5_mn  <= s4_mn;
      s5_sec <= s4_sec;
    end
  end

  // stage 6: quotient correction, channel routing, output register
  logic [XW-1:0] q_times15, rem;
  logic [OW-1:0] q_fix, ramp_val;
  logic [OW-1:0] red_next, green_next, blue_next;

  always_comb begin
    q_times15 = XW'({s5_q, 4'b0000}) - XW'(s5_q);
    rem       = s5_x - q_times15;
    q_fix     = s5_q + OW'(rem >= FIFTEEN);
    ramp_val  = s5_mn + q_fix;
  end

  hlsrgb_select #(
    .FRAC_BITS (FRAC_BITS)
  ) u_select (
    .sector (s5_sec),
    .mx     (s5_mx),
    .mn     (s5_mn),
    .ramp   (ramp_val),
    .red    (red_next),
    .green  (green_next),
    .blue   (blue_next)
  );

  always_ff @(posedge clk) begin
    if (ld6) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && s1_v && s5_v))
    else $error("input stalled while pipeline has room");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    s3_v |-> (s3_mn <= s3_mx))
    else $error("min above max");

  a_recip_error: assert property (@(posedge clk) disable iff (rst)
    s5_v |-> (rem < (FIFTEEN + FIFTEEN)))
    else $error("reciprocal estimate off by more than one");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= ONE_U && green <= ONE_U && blue <= ONE_U))
    else $error("output channel above full scale");

endmodule

`default_nettype wire

@@ hw/rtl/hlsrgb_select.sv @@
// hlsrgb_select: routes max, min and ramp values to red, green and blue by sector
// depends on hlsrgb_pkg (sector_t)
`default_nettype none

module hlsrgb_select #(
  parameter int FRAC_BITS = hlsrgb_pkg::FRAC_BITS_DEF
) (
  input  hlsrgb_pkg::sector_t   sector,
  input  wire  [FRAC_BITS:0]    mx,
  input  wire  [FRAC_BITS:0]    mn,
  input  wire  [FRAC_BITS:0]    ramp,
  output logic [FRAC_BITS:0]    red,
  output logic [FRAC_BITS:0]    green,
  output logic [FRAC_BITS:0]    blue
);
  import hlsrgb_pkg::*;

  always_comb begin
    case (sector)
      SEC_R_MAX_G_UP: begin
        red = mx;   green = ramp; blue = mn;
      end
      SEC_G_MAX_R_DOWN: begin
        red = ramp; green = mx;   blue = mn;
      end
      SEC_G_MAX_B_UP: begin
        red = mn;   green = mx;   blue = ramp;
      end
      SEC_B_MAX_G_DOWN: begin
        red = mn;   green = ramp; blue = mx;
      end
      SEC_B_MAX_R_UP: begin
        red = ramp; green = mn;   blue = mx;
      end
      SEC_R_MAX_B_DOWN: begin
        red = mx;   green = mn;   blue = ramp;
      end
      default: begin
        red = mn;   green = mn;   blue = mn;
      end
    endcase
  end

endmodule

`default_nettype wire
